>>> rtl/core/i2cm_pkg.sv
`default_nettype none
package i2cm_pkg;

  // bus commands carried by an input item
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_WACK  = 3'd5,
    CMD_ACK   = 3'd6,
    CMD_NACK  = 3'd7
  } cmd_t;

  // sequencer phases, one-hot
  typedef enum logic [16:0] {
    PH_IDLE = 17'h00001,
    PH_ST1  = 17'h00002,
    PH_ST2  = 17'h00004,
    PH_ST3  = 17'h00008,
    PH_SP1  = 17'h00010,
    PH_SP2  = 17'h00020,
    PH_AK1  = 17'h00040,
    PH_AK2  = 17'h00080,
    PH_WA1  = 17'h00100,
    PH_WA2  = 17'h00200,
    PH_WAP  = 17'h00400,
    PH_WR1  = 17'h00800,
    PH_WR2  = 17'h01000,
    PH_WR3  = 17'h02000,
    PH_RD0  = 17'h04000,
    PH_RD1  = 17'h08000,
    PH_RD2  = 17'h10000
  } phase_t;

  // register map
  localparam logic REG_DELAY = 1'b0;
  localparam logic REG_POLL  = 1'b1;

  localparam logic [15:0] DELAY_RST = 16'd5;
  localparam logic [7:0]  POLL_RST  = 8'd250;
  localparam int unsigned BITS_PER_BYTE = 8;

  // configuration seen by the sequencer
  typedef struct packed {
    logic [15:0] delay_ticks;
    logic [7:0]  ack_poll_limit;
  } cfg_t;

  // complete sequencer state, also the result of one tick
  typedef struct packed {
    phase_t      phase;
    cmd_t        cur_cmd;
    logic [15:0] dly_cnt;
    logic [3:0]  bit_cnt;
    logic [7:0]  shift;
    logic [7:0]  poll_cnt;
    logic        scl;
    logic        sda;
    logic        sda_en;
    logic        miss;
    logic        done;
    logic [7:0]  rx_byte;
    logic        ack_lvl;
  } seq_st_t;

endpackage
`default_nettype wire

>>> rtl/core/i2c_master_controller.sv
// latency: a result item is offered in the cycle after its tick item is accepted
// throughput: one tick item per cycle while results are taken; the whole bus step is one pass of the
//   phase sequencer between the state registers and the result register
// in_ready stays high while the result register is empty or being taken
// reset (rst_n low, synchronous): bus idle, scl high, sda high and driven,
//   flags and counters cleared, delay_ticks 5, ack_poll_limit 250
`default_nettype none
module i2c_master_controller
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tick items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_command,
  input  wire logic [7:0]  in_write_data,
  input  wire logic        in_ack_after_read,
  input  wire logic        in_sda_sample,
  // result items
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_scl_level,
  output logic             out_sda_level,
  output logic             out_sda_enable,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [7:0]       out_read_byte,
  output logic             out_ack_missing,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t    cfg;
  seq_st_t st_nxt;
  logic    step;
  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    scl_r, sda_r, sda_en_r, busy_r, done_r, miss_r;
  logic [7:0] rd_r;

  assign in_ready = !out_valid_r || out_ready;
  assign step     = in_valid && in_ready;

  i2cm_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  i2cm_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .cfg           (cfg),
    .command       (in_command),
    .write_data    (in_write_data),
    .ack_after_read(in_ack_after_read),
    .sda_sample    (in_sda_sample),
    .st_nxt        (st_nxt)
  );

  // result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step) begin
      scl_r    <= st_nxt.scl;
      sda_r    <= st_nxt.sda;
      sda_en_r <= st_nxt.sda_en;
      busy_r   <= (st_nxt.phase != PH_IDLE);
      done_r   <= st_nxt.done;
      rd_r     <= st_nxt.rx_byte;
      miss_r   <= st_nxt.miss;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl_level   = scl_r;
  assign out_sda_level   = sda_r;
  assign out_sda_enable  = sda_en_r;
  assign out_busy_res    = busy_r;
  assign out_done_res    = done_r;
  assign out_read_byte   = rd_r;
  assign out_ack_missing = miss_r;

  // a held result blocks the next tick
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("tick accepted over a waiting result");

  // every accepted tick yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("accepted tick gave no result");

  // done and busy never both set in one result
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(done_r && busy_r))
    else $error("done and busy together");

endmodule
`default_nettype wire

>>> rtl/core/i2cm_regs.sv
`default_nettype none
module i2cm_regs
  import i2cm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  logic [15:0] delay_r;
  logic [7:0]  poll_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RST;
      poll_r  <= POLL_RST;
    end else if (wr_en) begin
      if (cfg_paddr[2] == REG_DELAY) begin
        delay_r <= cfg_pwdata[15:0];
      end else begin
        poll_r <= cfg_pwdata[7:0];
      end
    end
  end

  // read back
  always_comb begin
    if (cfg_paddr[2] == REG_POLL) begin
      cfg_prdata = {24'd0, poll_r};
    end else begin
      cfg_prdata = {16'd0, delay_r};
    end
  end

  assign cfg.delay_ticks    = delay_r;
  assign cfg.ack_poll_limit = poll_r;

endmodule
`default_nettype wire

>>> rtl/core/i2cm_seq.sv
`default_nettype none
module i2cm_seq
  import i2cm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  cfg_t            cfg,
  input  wire logic [2:0] command,
  input  wire logic [7:0] write_data,
  input  wire logic       ack_after_read,
  input  wire logic       sda_sample,
  output seq_st_t         st_nxt
);

  seq_st_t     st_r;
  seq_st_t     s;
  logic [15:0] dly_load;
  logic [15:0] dly_dec;
  logic [3:0]  bc_inc;
  logic [7:0]  sh_next;
  logic        lvl;

  // segment length, zero treated as one
  assign dly_load = (cfg.delay_ticks == 16'd0) ? 16'd1 : cfg.delay_ticks;
  assign dly_dec  = (st_r.dly_cnt != 16'd0) ? st_r.dly_cnt - 16'd1 : st_r.dly_cnt;
  assign bc_inc   = st_r.bit_cnt + 4'd1;
  assign sh_next  = {st_r.shift[6:0], 1'b0};
  assign lvl      = st_r.sda;

  // one tick of the sequencer
  always_comb begin
    s = st_r;
    s.done = 1'b0;
    case (st_r.phase)
      PH_IDLE: begin
        if (cmd_t'(command) != CMD_NONE) begin
          s.cur_cmd = cmd_t'(command);
          s.dly_cnt = dly_load;
          s.sda_en  = 1'b1;
          case (cmd_t'(command))
            CMD_START: begin
              s.phase = PH_ST1; s.scl = 1'b1; s.sda = 1'b1;
            end
            CMD_STOP: begin
              s.phase = PH_SP1; s.scl = 1'b1; s.sda = 1'b0;
            end
            CMD_WRITE: begin
              s.shift = write_data; s.bit_cnt = 4'd0;
              s.phase = PH_WR1; s.scl = 1'b0; s.sda = write_data[7];
            end
            CMD_READ: begin
              s.shift = 8'd0; s.bit_cnt = 4'd0; s.ack_lvl = ~ack_after_read;
              s.phase = PH_RD0; s.scl = 1'b0; s.sda = 1'b1; s.sda_en = 1'b0;
            end
            CMD_WACK: begin
              s.phase = PH_WA1; s.sda = 1'b1; s.sda_en = 1'b0;
            end
            CMD_ACK: begin
              s.phase = PH_AK1; s.scl = 1'b0; s.sda = 1'b0;
            end
            default: begin
              s.phase = PH_AK1; s.scl = 1'b0; s.sda = 1'b1;
            end
          endcase
        end
      end
      // ack polling, one sample a tick
      PH_WAP: begin
        if (!sda_sample) begin
          s.miss = 1'b0; s.done = 1'b1; s.phase = PH_IDLE;
          s.scl = 1'b0; s.sda = 1'b1; s.sda_en = 1'b1;
        end else if (st_r.poll_cnt >= cfg.ack_poll_limit) begin
          s.miss = 1'b1; s.phase = PH_SP1; s.dly_cnt = dly_load;
          s.scl = 1'b1; s.sda = 1'b0; s.sda_en = 1'b1;
        end else begin
          s.poll_cnt = st_r.poll_cnt + 8'd1;
        end
      end
      // timed segments
      default: begin
        s.dly_cnt = dly_dec;
        if (dly_dec == 16'd0) begin
          case (st_r.phase)
            PH_ST1: begin
              s.phase = PH_ST2; s.dly_cnt = dly_load;
              s.scl = 1'b1; s.sda = 1'b0; s.sda_en = 1'b1;
            end
            PH_ST2: begin
              s.phase = PH_ST3; s.dly_cnt = dly_load;
              s.scl = 1'b0; s.sda = 1'b0; s.sda_en = 1'b1;
            end
            PH_ST3: begin
              s.phase = PH_IDLE; s.done = 1'b1;
              s.scl = 1'b0; s.sda = 1'b0; s.sda_en = 1'b1;
            end
            PH_SP1: begin
              s.phase = PH_SP2; s.dly_cnt = dly_load;
              s.scl = 1'b1; s.sda = 1'b1; s.sda_en = 1'b1;
            end
            PH_SP2: begin
              s.phase = PH_IDLE; s.done = 1'b1;
              s.scl = 1'b1; s.sda = 1'b1; s.sda_en = 1'b1;
            end
            PH_AK1: begin
              s.phase = PH_AK2; s.dly_cnt = dly_load;
              s.scl = 1'b1; s.sda = lvl; s.sda_en = 1'b1;
            end
            PH_AK2: begin
              s.phase = PH_IDLE; s.done = 1'b1; s.sda = lvl; s.sda_en = 1'b1;
              if (st_r.cur_cmd == CMD_READ) begin
                s.rx_byte = st_r.shift; s.scl = 1'b0;
              end else begin
                s.scl = 1'b1;
              end
            end
            PH_WA1: begin
              s.phase = PH_WA2; s.dly_cnt = dly_load;
              s.scl = 1'b1; s.sda = 1'b1; s.sda_en = 1'b0;
            end
            PH_WA2: begin
              s.phase = PH_WAP; s.poll_cnt = 8'd0;
            end
            PH_WR1: begin
              s.phase = PH_WR2; s.dly_cnt = dly_load;
              s.scl = 1'b1; s.sda = lvl; s.sda_en = 1'b1;
            end
            PH_WR2: begin
              s.phase = PH_WR3; s.dly_cnt = dly_load;
              s.scl = 1'b0; s.sda = lvl; s.sda_en = 1'b1;
            end
            PH_WR3: begin
              s.bit_cnt = bc_inc;
              if (bc_inc >= 4'(BITS_PER_BYTE)) begin
                s.phase = PH_IDLE; s.done = 1'b1;
                s.scl = 1'b0; s.sda = lvl; s.sda_en = 1'b1;
              end else begin
                s.shift = sh_next; s.phase = PH_WR1; s.dly_cnt = dly_load;
                s.scl = 1'b0; s.sda = sh_next[7]; s.sda_en = 1'b1;
              end
            end
            PH_RD0: begin
              s.phase = PH_RD1; s.dly_cnt = dly_load;
              s.scl = 1'b1; s.sda = 1'b1; s.sda_en = 1'b0;
            end
            // sample at the end of scl high
            PH_RD1: begin
              s.shift = {st_r.shift[6:0], sda_sample};
              s.phase = PH_RD2; s.dly_cnt = dly_load;
              s.scl = 1'b0; s.sda = 1'b1; s.sda_en = 1'b0;
            end
            PH_RD2: begin
              s.bit_cnt = bc_inc; s.dly_cnt = dly_load;
              if (bc_inc >= 4'(BITS_PER_BYTE)) begin
                s.phase = PH_AK1;
                s.scl = 1'b0; s.sda = st_r.ack_lvl; s.sda_en = 1'b1;
              end else begin
                s.phase = PH_RD1;
                s.scl = 1'b1; s.sda = 1'b1; s.sda_en = 1'b0;
              end
            end
            default: begin
              s.phase = PH_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  assign st_nxt = s;

  // state advances once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase    <= PH_IDLE;
      st_r.cur_cmd  <= CMD_NONE;
      st_r.dly_cnt  <= 16'd0;
      st_r.bit_cnt  <= 4'd0;
      st_r.shift    <= 8'd0;
      st_r.poll_cnt <= 8'd0;
      st_r.scl      <= 1'b1;
      st_r.sda      <= 1'b1;
      st_r.sda_en   <= 1'b1;
      st_r.miss     <= 1'b0;
      st_r.done     <= 1'b0;
      st_r.rx_byte  <= 8'd0;
      st_r.ack_lvl  <= 1'b0;
    end else if (step) begin
      st_r <= s;
    end
  end

  // done only ever shows with the bus idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.done |-> (st_r.phase == PH_IDLE))
    else $error("done raised while a command is in progress");

  // no tick, no change of phase
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(st_r.phase))
    else $error("phase moved without an accepted item");

  // bit counter never passes one byte
  a_bits: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bit_cnt <= 4'(BITS_PER_BYTE))
    else $error("bit counter overran");

endmodule
`default_nettype wire
